// ===== rtl/core/tgc_pkg.sv =====
`default_nettype none

package tgc_pkg;

   localparam int COORD_BITS = 12;
   localparam int TIME_BITS  = 32;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_IDX_BITS  = 3;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [TIME_BITS-1:0]  stamp_type;

   typedef enum logic [2:0] {
      GESTURE_NONE   = 3'd0,
      GESTURE_TAP    = 3'd1,
      GESTURE_DOUBLE = 3'd2,
      GESTURE_LEFT   = 3'd3,
      GESTURE_RIGHT  = 3'd4,
      GESTURE_UP     = 3'd5,
      GESTURE_DOWN   = 3'd6
   } gesture_kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MIN_SWIPE_DISTANCE = 3'd0,
      CSR_MAX_SWIPE_TIME     = 3'd1,
      CSR_TAP_SLOP           = 3'd2,
      CSR_MAX_TAP_TIME       = 3'd3,
      CSR_DOUBLE_TAP_WINDOW  = 3'd4
   } csr_index_type;

   localparam coord_type MIN_SWIPE_DISTANCE_RESET = COORD_BITS'(40);
   localparam stamp_type MAX_SWIPE_TIME_RESET     = TIME_BITS'(500);
   localparam coord_type TAP_SLOP_RESET           = COORD_BITS'(10);
   localparam stamp_type MAX_TAP_TIME_RESET       = TIME_BITS'(300);
   localparam stamp_type DOUBLE_TAP_WINDOW_RESET  = TIME_BITS'(350);

   typedef struct packed {
      logic      touch_pressed;
      coord_type pos_x;
      coord_type pos_y;
      stamp_type now_ms;
   } req_word_type;

   typedef struct packed {
      gesture_kind_type gesture_kind;
      coord_type        end_x;
      coord_type        end_y;
      coord_type        begin_x;
      coord_type        begin_y;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== rtl/core/touch_gesture_classifier.sv =====
`default_nettype none

// channel   | direction | handshake          | word
// ----------+-----------+--------------------+-------------------------------
// req       | in        | req_valid/req_ready | touch sample
// rsp       | out       | rsp_valid/rsp_ready | gesture result, one per sample
// csr       | in/out    | APB, pready high    | five tuning registers
//
// One sample per cycle unless the rsp side stalls. A sample is classified in
// the cycle it is accepted and its result lands in the output register; the
// press/tap tracking registers update at the same edge. req_ready is high
// whenever the output register is empty or being drained, so a stalled rsp
// side stops intake only while the output register is full. Synchronous reset
// clears tracking state, the output valid and the registers to their defaults.

module touch_gesture_classifier (
   input  wire                                  clock,
   input  wire                                  reset,

   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  tgc_pkg::req_word_type                req_word,

   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output tgc_pkg::rsp_word_type                rsp_word,

   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [tgc_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire  [tgc_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [tgc_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   tgc_pkg::coord_type min_swipe_distance_ff;
   tgc_pkg::stamp_type max_swipe_time_ff;
   tgc_pkg::coord_type tap_slop_ff;
   tgc_pkg::stamp_type max_tap_time_ff;
   tgc_pkg::stamp_type double_tap_window_ff;

   logic               press_active_ff, press_active_in;
   tgc_pkg::coord_type start_x_ff, start_x_in;
   tgc_pkg::coord_type start_y_ff, start_y_in;
   tgc_pkg::stamp_type start_time_ff, start_time_in;
   tgc_pkg::coord_type latest_x_ff, latest_x_in;
   tgc_pkg::coord_type latest_y_ff, latest_y_in;
   logic               tap_pending_ff, tap_pending_in;
   tgc_pkg::stamp_type tap_time_ff, tap_time_in;

   logic                  rsp_valid_ff;
   tgc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic                                  req_take;
   logic                                  csr_write;
   tgc_pkg::csr_index_type                csr_index;
   tgc_pkg::stamp_type                    dur, since_tap;
   tgc_pkg::coord_type                    ax, ay;
   logic                                  neg_x, neg_y, horiz;
   logic                                  swipe_time_ok, tap_ok, double_ok;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_take   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = tgc_pkg::csr_index_type'(csr_paddr[tgc_pkg::CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_swipe_distance_ff <= tgc_pkg::MIN_SWIPE_DISTANCE_RESET;
         max_swipe_time_ff     <= tgc_pkg::MAX_SWIPE_TIME_RESET;
         tap_slop_ff           <= tgc_pkg::TAP_SLOP_RESET;
         max_tap_time_ff       <= tgc_pkg::MAX_TAP_TIME_RESET;
         double_tap_window_ff  <= tgc_pkg::DOUBLE_TAP_WINDOW_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            tgc_pkg::CSR_MIN_SWIPE_DISTANCE:
               min_swipe_distance_ff <= csr_pwdata[tgc_pkg::COORD_BITS-1:0];
            tgc_pkg::CSR_MAX_SWIPE_TIME:
               max_swipe_time_ff <= csr_pwdata[tgc_pkg::TIME_BITS-1:0];
            tgc_pkg::CSR_TAP_SLOP:
               tap_slop_ff <= csr_pwdata[tgc_pkg::COORD_BITS-1:0];
            tgc_pkg::CSR_MAX_TAP_TIME:
               max_tap_time_ff <= csr_pwdata[tgc_pkg::TIME_BITS-1:0];
            tgc_pkg::CSR_DOUBLE_TAP_WINDOW:
               double_tap_window_ff <= csr_pwdata[tgc_pkg::TIME_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         tgc_pkg::CSR_MIN_SWIPE_DISTANCE:
            csr_prdata = tgc_pkg::CSR_DATA_BITS'(min_swipe_distance_ff);
         tgc_pkg::CSR_MAX_SWIPE_TIME:
            csr_prdata = tgc_pkg::CSR_DATA_BITS'(max_swipe_time_ff);
         tgc_pkg::CSR_TAP_SLOP:
            csr_prdata = tgc_pkg::CSR_DATA_BITS'(tap_slop_ff);
         tgc_pkg::CSR_MAX_TAP_TIME:
            csr_prdata = tgc_pkg::CSR_DATA_BITS'(max_tap_time_ff);
         tgc_pkg::CSR_DOUBLE_TAP_WINDOW:
            csr_prdata = tgc_pkg::CSR_DATA_BITS'(double_tap_window_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   // displacement magnitudes and time deltas (modulo 2^TIME_BITS)
   always_comb begin
      neg_x = latest_x_ff < start_x_ff;
      neg_y = latest_y_ff < start_y_ff;
      ax    = neg_x ? (start_x_ff - latest_x_ff) : (latest_x_ff - start_x_ff);
      ay    = neg_y ? (start_y_ff - latest_y_ff) : (latest_y_ff - start_y_ff);
      horiz = ax >= ay;
      dur       = req_word.now_ms - start_time_ff;
      since_tap = req_word.now_ms - tap_time_ff;
      swipe_time_ok = dur <= max_swipe_time_ff;
      tap_ok    = (ax <= tap_slop_ff) && (ay <= tap_slop_ff) && (dur <= max_tap_time_ff);
      double_ok = tap_pending_ff && (since_tap <= double_tap_window_ff);
   end

   always_comb begin
      press_active_in = press_active_ff;
      start_x_in      = start_x_ff;
      start_y_in      = start_y_ff;
      start_time_in   = start_time_ff;
      latest_x_in     = latest_x_ff;
      latest_y_in     = latest_y_ff;
      tap_pending_in  = tap_pending_ff;
      tap_time_in     = tap_time_ff;
      rsp_word_in     = '0;
      rsp_word_in.gesture_kind = tgc_pkg::GESTURE_NONE;

      if (req_word.touch_pressed) begin
         if (!press_active_ff) begin
            press_active_in = 1'b1;
            start_x_in      = req_word.pos_x;
            start_y_in      = req_word.pos_y;
            start_time_in   = req_word.now_ms;
         end
         latest_x_in = req_word.pos_x;
         latest_y_in = req_word.pos_y;
      end else if (press_active_ff) begin
         press_active_in     = 1'b0;
         rsp_word_in.end_x   = latest_x_ff;
         rsp_word_in.end_y   = latest_y_ff;
         rsp_word_in.begin_x = start_x_ff;
         rsp_word_in.begin_y = start_y_ff;
         priority if (horiz && ax >= min_swipe_distance_ff && swipe_time_ok) begin
            tap_pending_in = 1'b0;
            rsp_word_in.gesture_kind = neg_x ? tgc_pkg::GESTURE_LEFT
                                             : tgc_pkg::GESTURE_RIGHT;
         end else if (!horiz && ay >= min_swipe_distance_ff && swipe_time_ok) begin
            tap_pending_in = 1'b0;
            rsp_word_in.gesture_kind = neg_y ? tgc_pkg::GESTURE_UP
                                             : tgc_pkg::GESTURE_DOWN;
         end else if (tap_ok && double_ok) begin
            tap_pending_in = 1'b0;
            rsp_word_in.gesture_kind = tgc_pkg::GESTURE_DOUBLE;
         end else if (tap_ok) begin
            tap_pending_in = 1'b1;
            tap_time_in    = req_word.now_ms;
            rsp_word_in.gesture_kind = tgc_pkg::GESTURE_TAP;
         end else begin
            tap_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_active_ff <= 1'b0;
         start_x_ff      <= '0;
         start_y_ff      <= '0;
         start_time_ff   <= '0;
         latest_x_ff     <= '0;
         latest_y_ff     <= '0;
         tap_pending_ff  <= 1'b0;
         tap_time_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_take) begin
            press_active_ff <= press_active_in;
            start_x_ff      <= start_x_in;
            start_y_ff      <= start_y_in;
            start_time_ff   <= start_time_in;
            latest_x_ff     <= latest_x_in;
            latest_y_ff     <= latest_y_in;
            tap_pending_ff  <= tap_pending_in;
            tap_time_ff     <= tap_time_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

// ===== bench/gesture_checker.sv =====
`timescale 1ns / 100ps

module gesture_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  tgc_pkg::req_word_type              req_word,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  tgc_pkg::rsp_word_type              rsp_word,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [tgc_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  wire  [tgc_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  wire  [tgc_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   input  wire                                csr_pready,
   output int                                 fail_count,
   output int                                 outstanding
);

   tgc_pkg::rsp_word_type expected_gestures[$];

   tgc_pkg::coord_type min_swipe_dist_r;
   tgc_pkg::stamp_type max_swipe_time_r;
   tgc_pkg::coord_type tap_slop_r;
   tgc_pkg::stamp_type max_tap_time_r;
   tgc_pkg::stamp_type double_tap_window_r;

   logic               pressing;
   tgc_pkg::coord_type anchor_x, anchor_y;
   tgc_pkg::stamp_type anchor_time;
   tgc_pkg::coord_type last_x, last_y;
   logic               tap_armed;
   tgc_pkg::stamp_type tap_stamp;

   function automatic void check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         fail_count++;
         $error("%s expected %0d got %0d", name, want, got);
      end
   endfunction

   function automatic logic [31:0] csr_value(input logic [tgc_pkg::CSR_IDX_BITS-1:0] idx);
      case (idx)
         tgc_pkg::CSR_MIN_SWIPE_DISTANCE: return 32'(min_swipe_dist_r);
         tgc_pkg::CSR_MAX_SWIPE_TIME:     return 32'(max_swipe_time_r);
         tgc_pkg::CSR_TAP_SLOP:           return 32'(tap_slop_r);
         tgc_pkg::CSR_MAX_TAP_TIME:       return 32'(max_tap_time_r);
         tgc_pkg::CSR_DOUBLE_TAP_WINDOW:  return 32'(double_tap_window_r);
         default:                         return 32'd0;
      endcase
   endfunction

   // advances the press/tap tracking by one sample and returns its gesture word
   function automatic tgc_pkg::rsp_word_type classify(input tgc_pkg::req_word_type s);
      tgc_pkg::rsp_word_type r;
      int                    dx, dy, ax, ay;
      tgc_pkg::stamp_type    dur, since;
      logic                  horiz;
      r = '0;
      if (s.touch_pressed) begin
         if (!pressing) begin
            pressing    = 1'b1;
            anchor_x    = s.pos_x;
            anchor_y    = s.pos_y;
            anchor_time = s.now_ms;
         end
         last_x = s.pos_x;
         last_y = s.pos_y;
         return r;
      end
      if (!pressing) return r;
      pressing  = 1'b0;
      r.end_x   = last_x;
      r.end_y   = last_y;
      r.begin_x = anchor_x;
      r.begin_y = anchor_y;
      dur   = s.now_ms - anchor_time;
      dx    = int'(last_x) - int'(anchor_x);
      dy    = int'(last_y) - int'(anchor_y);
      ax    = (dx < 0) ? -dx : dx;
      ay    = (dy < 0) ? -dy : dy;
      horiz = (ax >= ay);
      if (horiz && ax >= int'(min_swipe_dist_r) && dur <= max_swipe_time_r) begin
         tap_armed      = 1'b0;
         r.gesture_kind = (dx < 0) ? tgc_pkg::GESTURE_LEFT : tgc_pkg::GESTURE_RIGHT;
      end else if (!horiz && ay >= int'(min_swipe_dist_r) && dur <= max_swipe_time_r) begin
         tap_armed      = 1'b0;
         r.gesture_kind = (dy < 0) ? tgc_pkg::GESTURE_UP : tgc_pkg::GESTURE_DOWN;
      end else if (ax <= int'(tap_slop_r) && ay <= int'(tap_slop_r)
                   && dur <= max_tap_time_r) begin
         since = s.now_ms - tap_stamp;
         if (tap_armed && since <= double_tap_window_r) begin
            tap_armed      = 1'b0;
            r.gesture_kind = tgc_pkg::GESTURE_DOUBLE;
         end else begin
            tap_armed      = 1'b1;
            tap_stamp      = s.now_ms;
            r.gesture_kind = tgc_pkg::GESTURE_TAP;
         end
      end else begin
         tap_armed = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      tgc_pkg::rsp_word_type want;
      if (reset) begin
         expected_gestures.delete();
         min_swipe_dist_r    = tgc_pkg::MIN_SWIPE_DISTANCE_RESET;
         max_swipe_time_r    = tgc_pkg::MAX_SWIPE_TIME_RESET;
         tap_slop_r          = tgc_pkg::TAP_SLOP_RESET;
         max_tap_time_r      = tgc_pkg::MAX_TAP_TIME_RESET;
         double_tap_window_r = tgc_pkg::DOUBLE_TAP_WINDOW_RESET;
         pressing    = 1'b0;
         anchor_x    = '0;
         anchor_y    = '0;
         anchor_time = '0;
         last_x      = '0;
         last_y      = '0;
         tap_armed   = 1'b0;
         tap_stamp   = '0;
         outstanding <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[tgc_pkg::CSR_ADDR_BITS-1:2])
                  tgc_pkg::CSR_MIN_SWIPE_DISTANCE:
                     min_swipe_dist_r = tgc_pkg::coord_type'(csr_pwdata);
                  tgc_pkg::CSR_MAX_SWIPE_TIME:
                     max_swipe_time_r = tgc_pkg::stamp_type'(csr_pwdata);
                  tgc_pkg::CSR_TAP_SLOP:
                     tap_slop_r = tgc_pkg::coord_type'(csr_pwdata);
                  tgc_pkg::CSR_MAX_TAP_TIME:
                     max_tap_time_r = tgc_pkg::stamp_type'(csr_pwdata);
                  tgc_pkg::CSR_DOUBLE_TAP_WINDOW:
                     double_tap_window_r = tgc_pkg::stamp_type'(csr_pwdata);
                  default: ;
               endcase
            end else begin
               check_field("csr_prdata", csr_value(csr_paddr[tgc_pkg::CSR_ADDR_BITS-1:2]),
                           csr_prdata);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_gestures.size() == 0) begin
               fail_count++;
               $error("result word with no sample pending");
            end else begin
               want = expected_gestures.pop_front();
               check_field("gesture_kind", 32'(want.gesture_kind), 32'(rsp_word.gesture_kind));
               check_field("end_x", 32'(want.end_x), 32'(rsp_word.end_x));
               check_field("end_y", 32'(want.end_y), 32'(rsp_word.end_y));
               check_field("begin_x", 32'(want.begin_x), 32'(rsp_word.begin_x));
               check_field("begin_y", 32'(want.begin_y), 32'(rsp_word.begin_y));
            end
         end
         if (req_valid && req_ready) expected_gestures.push_back(classify(req_word));
         outstanding <= expected_gestures.size();
      end
   end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam logic [tgc_pkg::CSR_IDX_BITS-1:0] UNMAPPED_CSR = 3'd5;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   wire                               req_ready;
   tgc_pkg::req_word_type             req_word = '0;
   wire                               rsp_valid;
   logic                              rsp_ready = 1'b0;
   tgc_pkg::rsp_word_type             rsp_word;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [tgc_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [tgc_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   wire  [tgc_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   wire                               csr_pready;

   int                 fail_count;
   int                 outstanding;
   int                 sent = 0;
   bit                 calm = 1'b0;
   bit                 hold_rsp = 1'b0;
   int                 idle_run = 0;
   tgc_pkg::stamp_type last_release = '0;

   // shadow of the programmed registers, used only to aim the stimulus
   int                 msd_cfg = 40;
   tgc_pkg::stamp_type mst_cfg = 500;
   int                 slop_cfg = 10;
   tgc_pkg::stamp_type mtt_cfg = 300;
   tgc_pkg::stamp_type dtw_cfg = 350;

   touch_gesture_classifier DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   gesture_checker gesture_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial forever #1 clock = ~clock;

   function automatic tgc_pkg::req_word_type sample(input bit p, input int x, y,
                                                    input tgc_pkg::stamp_type t);
      tgc_pkg::req_word_type r;
      r.touch_pressed = p;
      r.pos_x         = tgc_pkg::coord_type'(x);
      r.pos_y         = tgc_pkg::coord_type'(y);
      r.now_ms        = t;
      return r;
   endfunction

   task automatic send_word(input tgc_pkg::req_word_type w);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      calm = ((sent / 48) % 5) == 4;
   endtask

   task automatic stroke(input int x0, y0, x1, y1, input tgc_pkg::stamp_type t0, dur,
                         input int moves, input bit lift);
      int k;
      send_word(sample(1'b1, x0, y0, t0));
      for (k = 0; k < moves; k++)
         send_word(sample(1'b1, $urandom_range(0, 4095), $urandom_range(0, 4095), t0 + k + 1));
      send_word(sample(1'b1, x1, y1, t0 + dur / 2));
      if (lift)
         send_word(sample(1'b0, $urandom_range(0, 4095), $urandom_range(0, 4095), t0 + dur));
   endtask

   task automatic place_axis(input int span, output int a, output int b);
      if ($urandom_range(0, 1)) begin
         a = $urandom_range(0, 4095 - span);
         b = a + span;
      end else begin
         a = $urandom_range(span, 4095);
         b = a - span;
      end
   endtask

   task automatic csr_access(input bit wr, input logic [tgc_pkg::CSR_IDX_BITS-1:0] idx,
                             input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= tgc_pkg::CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_csrs(input logic [31:0] msd, mst, slop, mtt, dtw);
      csr_access(1'b1, tgc_pkg::CSR_MIN_SWIPE_DISTANCE, msd);
      csr_access(1'b1, tgc_pkg::CSR_MAX_SWIPE_TIME, mst);
      csr_access(1'b1, tgc_pkg::CSR_TAP_SLOP, slop);
      csr_access(1'b1, tgc_pkg::CSR_MAX_TAP_TIME, mtt);
      csr_access(1'b1, tgc_pkg::CSR_DOUBLE_TAP_WINDOW, dtw);
      csr_access(1'b1, UNMAPPED_CSR, $urandom);
      csr_access(1'b0, tgc_pkg::CSR_MIN_SWIPE_DISTANCE, '0);
      csr_access(1'b0, tgc_pkg::CSR_MAX_SWIPE_TIME, '0);
      csr_access(1'b0, tgc_pkg::CSR_TAP_SLOP, '0);
      csr_access(1'b0, tgc_pkg::CSR_MAX_TAP_TIME, '0);
      csr_access(1'b0, tgc_pkg::CSR_DOUBLE_TAP_WINDOW, '0);
      msd_cfg  = int'(msd[tgc_pkg::COORD_BITS-1:0]);
      mst_cfg  = mst;
      slop_cfg = int'(slop[tgc_pkg::COORD_BITS-1:0]);
      mtt_cfg  = mtt;
      dtw_cfg  = dtw;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly well-formed strokes aimed at the thresholds, some noise and
   // strokes that never lift
   task automatic run_phase(input int n, input bit pressure);
      int                 start, span, side, x0, y0, x1, y1, tmp;
      bit                 held;
      tgc_pkg::stamp_type dur, interval;
      start = sent;
      held  = 1'b0;
      while (sent - start < n) begin
         if (pressure && !held && sent - start >= n / 2) begin
            hold_rsp = 1'b1;
            held     = 1'b1;
         end
         if ($urandom_range(0, 99) < 15) begin
            send_word(sample(1'($urandom_range(0, 1)), $urandom_range(0, 4095),
                             $urandom_range(0, 4095), $urandom));
         end else begin
            case ($urandom_range(0, 2))
               0:       span = $urandom_range(0, slop_cfg + 1);
               1:       span = msd_cfg + int'($urandom_range(0, 2)) - 1;
               default: span = $urandom_range(0, 4095);
            endcase
            if (span < 0) span = 0;
            if (span > 4095) span = 4095;
            side = ($urandom_range(0, 3) == 0) ? span : $urandom_range(0, span);
            if ($urandom_range(0, 1)) begin
               tmp  = span;
               span = side;
               side = tmp;
            end
            place_axis(span, x0, x1);
            place_axis(side, y0, y1);
            case ($urandom_range(0, 4))
               0:       dur = mtt_cfg + $urandom_range(0, 6) - 3;
               1:       dur = mst_cfg + $urandom_range(0, 6) - 3;
               2:       dur = $urandom_range(0, 400);
               3:       dur = $urandom;
               default: dur = '0;
            endcase
            case ($urandom_range(0, 2))
               0:       interval = dtw_cfg + $urandom_range(0, 6) - 3;
               1:       interval = $urandom_range(0, 1000);
               default: interval = $urandom;
            endcase
            last_release = last_release + interval;
            stroke(x0, y0, x1, y1, last_release - dur, dur, $urandom_range(0, 3),
                   $urandom_range(0, 9) != 0);
         end
      end
      wait_drained();
   endtask

   initial begin
      int stall;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 6);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall    = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      while (idle_run < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (csr_psel && csr_penable && csr_pready))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // release with nothing pressed, then tap, double tap, four swipes,
      // a release with no gesture and a tap across the timestamp wrap
      send_word(sample(1'b0, 4095, 4095, 32'hFFFF_FFFF));
      stroke(100, 100, 100, 100, 1000, 100, 0, 1'b1);
      stroke(100, 100, 102, 98, 1200, 50, 0, 1'b1);
      stroke(0, 0, 4095, 0, 2000, 200, 1, 1'b1);
      stroke(4095, 10, 0, 10, 2500, 500, 0, 1'b1);
      stroke(500, 4095, 500, 0, 2600, 10, 0, 1'b1);
      stroke(500, 0, 500, 4095, 2700, 0, 0, 1'b1);
      stroke(1000, 1000, 1020, 1000, 3000, 2000, 0, 1'b1);
      stroke(2000, 2000, 2005, 2003, 32'hFFFF_FF00, 272, 0, 1'b1);
      last_release = 32'h0000_0010;

      run_phase(200, 1'b0);
      program_csrs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      run_phase(220, 1'b0);
      program_csrs(32'd4095, 32'hFFFF_FFFF, 32'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_phase(220, 1'b1);
      program_csrs($urandom_range(1, 200), $urandom_range(50, 1000), $urandom_range(0, 40),
                   $urandom_range(50, 600), $urandom_range(50, 800));
      run_phase(220, 1'b1);
      program_csrs($urandom, $urandom, $urandom, $urandom, $urandom);
      run_phase(220, 1'b0);
      program_csrs(32'd40, 32'd500, 32'd10, 32'd300, 32'd350);
      run_phase(220, 1'b0);
      program_csrs($urandom_range(1, 200), $urandom_range(50, 1000), $urandom_range(0, 40),
                   $urandom_range(50, 600), $urandom_range(50, 800));
      run_phase(220, 1'b0);

      if (fail_count == 0 && outstanding == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
